### hdl/midpoint_line_rasterizer_top_assert.svh
// Assertion macros used by the midpoint line rasteriser checker
`ifndef MIDPOINT_LINE_RASTERIZER_TOP_ASSERT_SVH
`define MIDPOINT_LINE_RASTERIZER_TOP_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge, masked in reset
`define MLR_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, masked in reset
`define MLR_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hdl/mlr_pkg.sv
// Shared widths, request codes and slope classes of the midpoint line rasteriser
`timescale 1ns / 1ps

package mlr_pkg;

   // coordinate width and derived widths
   localparam int COORD_W    = 11;
   localparam int DELTA_W    = COORD_W + 1;
   localparam int DEC_W      = COORD_W + 4;
   localparam int REQ_DATA_W = ((4 * COORD_W + 7) / 8) * 8;
   localparam int RSP_DATA_W = ((2 * COORD_W + 7) / 8) * 8;

   // request kinds carried in req_tuser
   typedef enum logic {
      REQ_START = 1'b0,
      REQ_NEXT  = 1'b1
   } req_kind_type;

   // stepping classes of a line
   typedef enum logic [2:0] {
      CLS_VERT       = 3'd0,
      CLS_HORZ       = 3'd1,
      CLS_SHALLOW_UP = 3'd2,   // slope in (0,1]
      CLS_STEEP_UP   = 3'd3,   // slope above 1
      CLS_STEEP_DN   = 3'd4,   // slope below -1
      CLS_SHALLOW_DN = 3'd5    // slope in [-1,0)
   } slope_class_type;

endpackage

### hdl/midpoint_line_rasterizer_top.sv
// Midpoint line rasteriser: one pixel per transaction, top level
`timescale 1ns / 1ps

// A start transaction (req_tuser = 0) carries both endpoints and returns the
// first pixel; each next transaction (req_tuser = 1) returns one further pixel,
// with rsp_tlast on the final endpoint, after which the block is idle. A next
// transaction while idle is consumed and returns nothing; a start while a line
// is running abandons it. The decision variable update and pixel step are
// combinational, between the stepping state registers and the result register,
// so a transaction can be accepted every cycle while req_tready is high, and
// the pixel appears on rsp in the cycle after acceptance. req_tready stays high
// while the result register is empty or being drained.
module midpoint_line_rasterizer_top import mlr_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // [0:0] req_type
   input  logic                  req_tuser,
   // [COORD_W-1:0] x_start, then y_start, x_end, y_end, zero padded
   input  logic [REQ_DATA_W-1:0] req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [COORD_W-1:0] pixel_x, then pixel_y, zero padded
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // last_pixel
   output logic                  rsp_tlast
);

   // stepping state
   logic [COORD_W-1:0]        cur_x_ff, cur_x_in;
   logic [COORD_W-1:0]        cur_y_ff, cur_y_in;
   logic [COORD_W-1:0]        stop_ff, stop_in;
   logic signed [DELTA_W-1:0] dy_ff, dy_in;
   logic signed [DELTA_W-1:0] dxn_ff, dxn_in;
   logic signed [DEC_W-1:0]   dec_ff, dec_in;
   slope_class_type           cls_ff, cls_in;
   logic                      active_ff, active_in;

   // result register
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [COORD_W-1:0]        pix_x_ff, pix_y_ff;
   logic                      last_ff;

   logic                      req_take;
   logic                      emit;
   logic                      last;

   // endpoint unpacking
   logic [COORD_W-1:0] xs, ys, xe, ye;
   logic [COORD_W-1:0] x1, y1, x2, y2;
   logic               swap;
   logic signed [DELTA_W-1:0] dy_new, dxn_new, adx_new;
   logic signed [DEC_W-1:0]   a_new, b_new;
   logic signed [DEC_W-1:0]   a_cur, b_cur;

   assign xs = req_tdata[COORD_W-1:0];
   assign ys = req_tdata[2*COORD_W-1:COORD_W];
   assign xe = req_tdata[3*COORD_W-1:2*COORD_W];
   assign ye = req_tdata[4*COORD_W-1:3*COORD_W];

   // handshake: take a transaction whenever the result slot is free or draining
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_take   = req_tvalid && req_tready;

   // reorder sloped lines so they run upward, and form the deltas
   assign swap    = ye < ys;
   assign x1      = swap ? xe : xs;
   assign y1      = swap ? ye : ys;
   assign x2      = swap ? xs : xe;
   assign y2      = swap ? ys : ye;
   assign dy_new  = $signed({1'b0, y2}) - $signed({1'b0, y1});
   assign dxn_new = $signed({1'b0, x1}) - $signed({1'b0, x2});
   assign adx_new = dxn_new[DELTA_W-1] ? -dxn_new : dxn_new;
   assign a_new   = DEC_W'(dy_new);
   assign b_new   = DEC_W'(dxn_new);
   assign a_cur   = DEC_W'(dy_ff);
   assign b_cur   = DEC_W'(dxn_ff);

   // line set-up and pixel stepping
   always_comb begin
      cur_x_in  = cur_x_ff;
      cur_y_in  = cur_y_ff;
      stop_in   = stop_ff;
      dy_in     = dy_ff;
      dxn_in    = dxn_ff;
      dec_in    = dec_ff;
      cls_in    = cls_ff;
      active_in = active_ff;
      emit      = 1'b0;
      last      = 1'b0;
      if (req_tuser == REQ_START) begin
         emit = 1'b1;
         if (xs == xe) begin
            cls_in   = CLS_VERT;
            cur_x_in = xs;
            cur_y_in = (ys <= ye) ? ys : ye;
            stop_in  = (ys <= ye) ? ye : ys;
            last     = (ys == ye);
         end else if (ys == ye) begin
            cls_in   = CLS_HORZ;
            cur_y_in = ys;
            cur_x_in = (xs <= xe) ? xs : xe;
            stop_in  = (xs <= xe) ? xe : xs;
            last     = 1'b0;
         end else begin
            cur_x_in = x1;
            cur_y_in = y1;
            dy_in    = dy_new;
            dxn_in   = dxn_new;
            if (dxn_new[DELTA_W-1]) begin
               if (dy_new <= adx_new) begin
                  cls_in  = CLS_SHALLOW_UP;
                  dec_in  = a_new + a_new + b_new;
                  stop_in = x2;
               end else begin
                  cls_in  = CLS_STEEP_UP;
                  dec_in  = -(b_new + b_new) - a_new;
                  stop_in = y2;
               end
            end else begin
               if (dy_new > adx_new) begin
                  cls_in  = CLS_STEEP_DN;
                  dec_in  = b_new + b_new - a_new;
                  stop_in = y2;
               end else begin
                  cls_in  = CLS_SHALLOW_DN;
                  dec_in  = b_new - (a_new + a_new);
                  stop_in = x2;
               end
            end
         end
         active_in = !last;
      end else if (active_ff) begin
         emit = 1'b1;
         case (cls_ff)
            CLS_VERT: begin
               cur_y_in = cur_y_ff + 1'b1;
               last     = (cur_y_in == stop_ff);
            end
            CLS_HORZ: begin
               cur_x_in = cur_x_ff + 1'b1;
               last     = (cur_x_in == stop_ff);
            end
            CLS_SHALLOW_UP: begin
               cur_x_in = cur_x_ff + 1'b1;
               if (dec_ff <= 0) begin
                  dec_in = dec_ff + a_cur + a_cur;
               end else begin
                  cur_y_in = cur_y_ff + 1'b1;
                  dec_in   = dec_ff + a_cur + a_cur + b_cur + b_cur;
               end
               last = (cur_x_in == stop_ff);
            end
            CLS_STEEP_UP: begin
               cur_y_in = cur_y_ff + 1'b1;
               if (dec_ff <= 0) begin
                  dec_in = dec_ff - (b_cur + b_cur);
               end else begin
                  cur_x_in = cur_x_ff + 1'b1;
                  dec_in   = dec_ff - (a_cur + a_cur + b_cur + b_cur);
               end
               last = (cur_y_in == stop_ff);
            end
            CLS_STEEP_DN: begin
               cur_y_in = cur_y_ff + 1'b1;
               if (dec_ff <= 0) begin
                  dec_in = dec_ff + b_cur + b_cur;
               end else begin
                  cur_x_in = cur_x_ff - 1'b1;
                  dec_in   = dec_ff + b_cur + b_cur - (a_cur + a_cur);
               end
               last = (cur_y_in == stop_ff);
            end
            default: begin
               // shallow downward slope; a tie takes the straight west step
               cur_x_in = cur_x_ff - 1'b1;
               if (dec_ff >= 0) begin
                  dec_in = dec_ff - (a_cur + a_cur);
               end else begin
                  cur_y_in = cur_y_ff + 1'b1;
                  dec_in   = dec_ff + b_cur + b_cur - (a_cur + a_cur);
               end
               last = (cur_x_in == stop_ff);
            end
         endcase
         active_in = !last;
      end
   end

   // result slot occupancy
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_take) begin
         rsp_valid_in = emit;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         cls_ff       <= CLS_VERT;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (req_take) begin
            active_ff <= active_in;
            cls_ff    <= cls_in;
         end
      end
   end

   // stepping state and result payload
   always_ff @(posedge clock) begin
      if (req_take) begin
         cur_x_ff <= cur_x_in;
         cur_y_ff <= cur_y_in;
         stop_ff  <= stop_in;
         dy_ff    <= dy_in;
         dxn_ff   <= dxn_in;
         dec_ff   <= dec_in;
         if (emit) begin
            pix_x_ff <= cur_x_in;
            pix_y_ff <= cur_y_in;
            last_ff  <= last;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'({pix_y_ff, pix_x_ff});
   assign rsp_tlast  = last_ff;

endmodule

### hdl/mlr_checker.sv
// Port-level assertion checker for the midpoint line rasteriser, with its bind
`timescale 1ns / 1ps

`include "midpoint_line_rasterizer_top_assert.svh"

module mlr_assertions import mlr_pkg::*; (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic                  req_tuser,
   input logic [REQ_DATA_W-1:0] req_tdata,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic                  rsp_tlast
);

   logic req_take;
   logic point_start;
   logic rsp_point;

   // accepted start transaction whose two endpoints coincide
   assign req_take    = req_tvalid && req_tready;
   assign point_start = req_take && (req_tuser == REQ_START)
                        && (req_tdata[COORD_W-1:0] == req_tdata[3*COORD_W-1:2*COORD_W])
                        && (req_tdata[2*COORD_W-1:COORD_W] == req_tdata[4*COORD_W-1:3*COORD_W]);
   assign rsp_point   = rsp_tvalid && rsp_tlast;

   // a stalled result transaction holds
   `MLR_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast), "stalled result changed")

   // an empty result slot never back-pressures the request side
   `MLR_ASSERT_IMP(a_req_ready, clock, reset, !rsp_tvalid, req_tready, "request stalled with empty result slot")

   // a result only appears after a request transaction
   `MLR_ASSERT_IMP(a_rsp_cause, clock, reset, $rose(rsp_tvalid), $past(req_take), "result without request")

   // a start with equal endpoints gives that single point flagged last
   `MLR_ASSERT_NXT(a_point_line, clock, reset, point_start, rsp_point && (rsp_tdata[2*COORD_W-1:0] == $past(req_tdata[2*COORD_W-1:0])), "single point line wrong")

endmodule

bind midpoint_line_rasterizer_top mlr_assertions u_mlr_assertions (.*);
